/* hdl/dftd_pkg.sv */
// Shared constants, types and the microcode table for the dual filter tilt detector.
// No dependencies; every other file in hdl/ imports this package.

package dftd_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int TEST_FRAC   = 8;
    localparam int Q_BITS      = 16;

    localparam int IN_W    = 16;
    localparam int IN_TW   = ((3 * IN_W + 7) / 8) * 8;
    localparam int OUT_TW  = 8;
    localparam int ALPHA_W = 16;
    localparam int C2_W    = 17;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 17;

    localparam int Y_W    = SAMPLE_BITS + FRAC_BITS;
    localparam int D_W    = Y_W + 1;
    localparam int SH_W   = FRAC_BITS - TEST_FRAC;
    localparam int V_W    = Y_W - SH_W;
    localparam int SQ_W   = 2 * V_W - 1;
    localparam int N2_W   = SQ_W + 1;
    localparam int HALF_W = N2_W / 2;
    localparam int A_W    = D_W;
    localparam int B_W    = V_W + 1;
    localparam int P_W    = A_W + B_W;
    localparam int PART_W = C2_W + HALF_W;
    localparam int CMP_W  = PART_W + HALF_W;

    localparam int PC_W     = 5;
    localparam int PROG_LEN = 23;
    localparam int LAST_PC  = PROG_LEN - 1;

    localparam logic [ALPHA_W-1:0] ALPHA_SLOW_RST = ALPHA_W'(328);
    localparam logic [ALPHA_W-1:0] ALPHA_FAST_RST = ALPHA_W'(6554);
    localparam logic [C2_W-1:0]    COS_SQ_RST     = C2_W'(49152);
    localparam logic signed [Y_W-1:0] Y_UP_RST =
        Y_W'(longint'(1) << (SAMPLE_BITS - 2 + FRAC_BITS));

    typedef enum logic [2:0] {
        OP_NONE,
        OP_FILT,
        OP_SQ,
        OP_CLO,
        OP_CHI
    } op_t;

    typedef enum logic [1:0] {
        C_NEVER,
        C_IN_EMPTY,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_ALPHA_SLOW,
        REG_ALPHA_FAST,
        REG_COS_FRONT,
        REG_COS_DOWN
    } reg_idx_t;

    typedef struct packed {
        logic            take;
        logic            emit;
        op_t             op;
        logic            filt;
        logic [1:0]      axis;
        logic            down;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } cw_t;

    typedef struct packed {
        op_t        op;
        logic       filt;
        logic [1:0] axis;
        logic       down;
    } tag_t;

    localparam cw_t NOP_WORD = '{take: 1'b0, emit: 1'b0, op: OP_NONE, filt: 1'b0,
                                 axis: 2'd0, down: 1'b0, cond: C_NEVER, target: '0};

    function automatic cw_t op_word(input op_t op, input logic filt,
                                    input logic [1:0] axis, input logic down);
        cw_t w;
        w      = NOP_WORD;
        w.op   = op;
        w.filt = filt;
        w.axis = axis;
        w.down = down;
        return w;
    endfunction

    // accept, filter updates, squares, the two-part threshold products, then the output step
    function automatic cw_t ucode(input logic [PC_W-1:0] pc);
        cw_t w;
        w = NOP_WORD;
        case (pc)
            PC_W'(0): begin
                w.take   = 1'b1;
                w.cond   = C_IN_EMPTY;
                w.target = PC_W'(0);
            end
            PC_W'(1):  w = op_word(OP_FILT, 1'b0, 2'd0, 1'b0);
            PC_W'(2):  w = op_word(OP_FILT, 1'b0, 2'd1, 1'b0);
            PC_W'(3):  w = op_word(OP_FILT, 1'b0, 2'd2, 1'b0);
            PC_W'(4):  w = op_word(OP_FILT, 1'b1, 2'd0, 1'b0);
            PC_W'(5):  w = op_word(OP_FILT, 1'b1, 2'd1, 1'b0);
            PC_W'(6):  w = op_word(OP_FILT, 1'b1, 2'd2, 1'b0);
            PC_W'(7):  w = op_word(OP_SQ,   1'b0, 2'd0, 1'b0);
            PC_W'(8):  w = op_word(OP_SQ,   1'b0, 2'd1, 1'b0);
            PC_W'(9):  w = op_word(OP_SQ,   1'b0, 2'd2, 1'b0);
            PC_W'(10): w = op_word(OP_SQ,   1'b1, 2'd0, 1'b0);
            PC_W'(11): w = op_word(OP_SQ,   1'b1, 2'd1, 1'b0);
            PC_W'(12): w = op_word(OP_SQ,   1'b1, 2'd2, 1'b0);
            PC_W'(13): w = op_word(OP_CLO,  1'b0, 2'd0, 1'b0);
            PC_W'(14): w = op_word(OP_CHI,  1'b0, 2'd0, 1'b0);
            PC_W'(15): w = op_word(OP_CLO,  1'b0, 2'd0, 1'b1);
            PC_W'(16): w = op_word(OP_CHI,  1'b0, 2'd0, 1'b1);
            PC_W'(17): w = op_word(OP_CLO,  1'b1, 2'd0, 1'b0);
            PC_W'(18): w = op_word(OP_CHI,  1'b1, 2'd0, 1'b0);
            PC_W'(19): w = op_word(OP_CLO,  1'b1, 2'd0, 1'b1);
            PC_W'(20): w = op_word(OP_CHI,  1'b1, 2'd0, 1'b1);
            PC_W'(LAST_PC): begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = PC_W'(LAST_PC);
            end
            default: w = NOP_WORD;
        endcase
        return w;
    endfunction

endpackage

/* hdl/dftd_seq.sv */
// Microcode sequencer: step counter, conditional jumps and the control word ROM.
// Depends on dftd_pkg.

module dftd_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           out_busy,
    output dftd_pkg::cw_t  cw
);
    import dftd_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign cw = ucode(pc_reg);

    always_comb begin
        case (cw.cond)
            C_IN_EMPTY: jump = !in_valid;
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b0;
        endcase
        if (jump) begin
            pc_next = cw.target;
        end else if (pc_reg == PC_W'(LAST_PC)) begin
            pc_next = '0;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hdl/dftd_dp.sv */
// Datapath: config registers, filter state, shared multiplier, threshold compare, output beat.
// Depends on dftd_pkg; driven by the control word from dftd_seq.

module dftd_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dftd_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [dftd_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    input  logic [dftd_pkg::IN_TW-1:0]    s_tdata,
    input  logic                          m_tready,
    input  dftd_pkg::cw_t                 cw,
    output logic                          out_busy,
    output logic                          m_tvalid,
    output logic [dftd_pkg::OUT_TW-1:0]   m_tdata
);
    import dftd_pkg::*;

    logic [ALPHA_W-1:0] alpha_slow_reg;
    logic [ALPHA_W-1:0] alpha_fast_reg;
    logic [C2_W-1:0]    cos_front_reg;
    logic [C2_W-1:0]    cos_down_reg;

    logic signed [SAMPLE_BITS-1:0] samp_reg [3];
    logic signed [Y_W-1:0]         y_reg [2][3];
    logic [N2_W-1:0]               n2_reg [2];
    logic [SQ_W-1:0]               cx_reg [2];
    logic [SQ_W-1:0]               cz_reg [2];
    logic [PART_W-1:0]             t_reg;
    logic [3:0]                    flag_reg;
    logic                          rec_reg;
    logic signed [P_W-1:0]         prod_reg;
    tag_t                          tag_reg;
    logic                          m_tvalid_reg;
    logic [OUT_TW-1:0]             m_tdata_reg;

    logic                          accept;
    logic                          emit_fire;
    logic                          rec_next;
    logic signed [SAMPLE_BITS-1:0] samp_sel;
    logic signed [Y_W-1:0]         y_sel;
    logic signed [Y_W-1:0]         x_ext;
    logic signed [D_W-1:0]         diff;
    logic [V_W-1:0]                v_sel;
    logic [N2_W-1:0]               n2_sel;
    logic [ALPHA_W-1:0]            alpha_sel;
    logic [C2_W-1:0]               c2_sel;
    logic signed [A_W-1:0]         op_a;
    logic signed [B_W-1:0]         op_b;

    logic signed [Y_W-1:0]         y_wb;
    logic signed [P_W-1:0]         rnd;
    logic signed [P_W-1:0]         step;
    logic [Y_W-1:0]                y_upd;
    logic [SQ_W-1:0]               sq;
    logic [PART_W-1:0]             part;
    logic [SQ_W-1:0]               comp;
    logic [C2_W-1:0]               c2_wb;
    logic [CMP_W-1:0]              lhs;
    logic [CMP_W-1:0]              rhs;
    logic                          sign_ok;
    logic                          pass;

    assign accept    = s_tvalid && cw.take;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign emit_fire = cw.emit && !out_busy;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // operand select for the issuing step
    always_comb begin
        case (cw.axis)
            2'd0: begin
                samp_sel = samp_reg[0];
                y_sel    = y_reg[cw.filt][0];
            end
            2'd1: begin
                samp_sel = samp_reg[1];
                y_sel    = y_reg[cw.filt][1];
            end
            default: begin
                samp_sel = samp_reg[2];
                y_sel    = y_reg[cw.filt][2];
            end
        endcase
        x_ext     = $signed({samp_sel, {FRAC_BITS{1'b0}}});
        diff      = $signed({x_ext[Y_W-1], x_ext}) - $signed({y_sel[Y_W-1], y_sel});
        v_sel     = y_sel[Y_W-1:SH_W];
        n2_sel    = n2_reg[cw.filt];
        alpha_sel = cw.filt ? alpha_fast_reg : alpha_slow_reg;
        c2_sel    = cw.down ? cos_down_reg : cos_front_reg;
        case (cw.op)
            OP_FILT: begin
                op_a = diff;
                op_b = $signed({{(B_W-ALPHA_W){1'b0}}, alpha_sel});
            end
            OP_SQ: begin
                op_a = $signed({{(A_W-V_W){v_sel[V_W-1]}}, v_sel});
                op_b = $signed({{(B_W-V_W){v_sel[V_W-1]}}, v_sel});
            end
            OP_CLO: begin
                op_a = $signed({{(A_W-HALF_W){1'b0}}, n2_sel[HALF_W-1:0]});
                op_b = $signed({{(B_W-C2_W){1'b0}}, c2_sel});
            end
            OP_CHI: begin
                op_a = $signed({{(A_W-HALF_W){1'b0}}, n2_sel[N2_W-1:HALF_W]});
                op_b = $signed({{(B_W-C2_W){1'b0}}, c2_sel});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // write-back of the product issued in the previous step
    always_comb begin
        case (tag_reg.axis)
            2'd0:    y_wb = y_reg[tag_reg.filt][0];
            2'd1:    y_wb = y_reg[tag_reg.filt][1];
            default: y_wb = y_reg[tag_reg.filt][2];
        endcase
        rnd     = prod_reg + P_W'(longint'(1) << (Q_BITS - 1));
        step    = rnd >>> Q_BITS;
        y_upd   = y_wb + step[Y_W-1:0];
        sq      = prod_reg[SQ_W-1:0];
        part    = prod_reg[PART_W-1:0];
        comp    = tag_reg.down ? cz_reg[tag_reg.filt] : cx_reg[tag_reg.filt];
        c2_wb   = tag_reg.down ? cos_down_reg : cos_front_reg;
        lhs     = CMP_W'({comp, {Q_BITS{1'b0}}});
        rhs     = CMP_W'(t_reg) + (CMP_W'(part) << HALF_W);
        sign_ok = tag_reg.down
                ? (!y_reg[tag_reg.filt][2][Y_W-1] && (|y_reg[tag_reg.filt][2][Y_W-2:SH_W]))
                : y_reg[tag_reg.filt][0][Y_W-1];
        pass    = sign_ok && !c2_wb[C2_W-1] && (lhs > rhs);
    end

    always_comb begin
        if (flag_reg[0] || flag_reg[1]) begin
            rec_next = 1'b1;
        end else if (flag_reg[2] && flag_reg[3]) begin
            rec_next = 1'b0;
        end else begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_slow_reg <= ALPHA_SLOW_RST;
            alpha_fast_reg <= ALPHA_FAST_RST;
            cos_front_reg  <= COS_SQ_RST;
            cos_down_reg   <= COS_SQ_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_ALPHA_SLOW: alpha_slow_reg <= cfg_wdata[ALPHA_W-1:0];
                REG_ALPHA_FAST: alpha_fast_reg <= cfg_wdata[ALPHA_W-1:0];
                REG_COS_FRONT:  cos_front_reg  <= cfg_wdata[C2_W-1:0];
                REG_COS_DOWN:   cos_down_reg   <= cfg_wdata[C2_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int f = 0; f < 2; f++) begin
                y_reg[f][0] <= '0;
                y_reg[f][1] <= '0;
                y_reg[f][2] <= Y_UP_RST;
            end
            tag_reg      <= '{op: OP_NONE, filt: 1'b0, axis: 2'd0, down: 1'b0};
            rec_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            tag_reg <= '{op: cw.op, filt: cw.filt, axis: cw.axis, down: cw.down};
            if (tag_reg.op == OP_FILT) begin
                y_reg[tag_reg.filt][tag_reg.axis] <= y_upd;
            end
            if (emit_fire) begin
                rec_reg      <= rec_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                samp_reg[i] <= s_tdata[i*IN_W +: SAMPLE_BITS];
            end
        end
        prod_reg <= P_W'(op_a) * P_W'(op_b);
        case (tag_reg.op)
            OP_SQ: begin
                case (tag_reg.axis)
                    2'd0: begin
                        n2_reg[tag_reg.filt] <= N2_W'(sq);
                        cx_reg[tag_reg.filt] <= sq;
                    end
                    2'd1: n2_reg[tag_reg.filt] <= n2_reg[tag_reg.filt] + N2_W'(sq);
                    default: begin
                        n2_reg[tag_reg.filt] <= n2_reg[tag_reg.filt] + N2_W'(sq);
                        cz_reg[tag_reg.filt] <= sq;
                    end
                endcase
            end
            OP_CLO:  t_reg <= part;
            OP_CHI:  flag_reg[{tag_reg.down, tag_reg.filt}] <= pass;
            default: ;
        endcase
        if (emit_fire) begin
            m_tdata_reg <= OUT_TW'({flag_reg, rec_next});
        end
    end

endmodule

/* hdl/dual_filter_tilt_detector_core.sv */
// Top level of the dual filter tilt detector: sequencer plus datapath.
// Depends on dftd_pkg, dftd_seq and dftd_dp.
//
//   channel  dir  beat contents (lowest bit first)
//   s_       in   tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
//   m_       out  tdata: recording, slow_front, fast_front, slow_down, fast_down, 3 zero
//   cfg_     in   index 0 alpha_slow, 1 alpha_fast, 2 cos_sq_front, 3 cos_sq_down
//
// Each sample runs 20 products through the one shared multiplier,
// issued one per step by the microcode, plus the accept, write-back and output steps.
// Reset is synchronous; filters restart at rest (z up) and the flag clears.
// A result waits in the output register while the next sample is taken; the
// sequencer holds at its last step only if that register is still full.

module dual_filter_tilt_detector_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dftd_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [dftd_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dftd_pkg::IN_TW-1:0]    s_tdata,   // accel_x, accel_y, accel_z
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dftd_pkg::OUT_TW-1:0]   m_tdata    // recording, slow_front, fast_front,
                                                     // slow_down, fast_down
);
    import dftd_pkg::*;

    cw_t  cw;
    logic out_busy;

    assign s_tready = cw.take;

    dftd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .cw       (cw)
    );

    dftd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cw        (cw),
        .out_busy  (out_busy),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

/* hdl/dftd_checker.sv */
// Port-level checks for dual_filter_tilt_detector_core, attached by bind.
// Depends on dftd_pkg.

module dftd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dftd_pkg::OUT_TW-1:0]   m_tdata
);
    import dftd_pkg::*;

    // one sample in flight: ready drops after each accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready stayed high after an accepted beat");

    // hold the result beat while the sink stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_front_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1] || m_tdata[2]) |-> m_tdata[0])
        else $error("recording clear with a forward-facing filter");

    a_down_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] && m_tdata[4] && !m_tdata[1] && !m_tdata[2]
        |-> !m_tdata[0])
        else $error("recording set with both filters pointing down");

endmodule

bind dual_filter_tilt_detector_core dftd_checker u_dftd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for dual_filter_tilt_detector_core: directed table plus posed random runs,
// each result checked against the table's expected flags or an in-bench model of the two filters and cone tests.
// Depends on dftd_pkg and the core RTL.

module tb;
    import dftd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 215;
    localparam int NUM_PHASES  = 7;
    localparam int DIR_ROWS    = 22;

    typedef struct packed {
        logic signed [IN_W-1:0] z;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] x;
    } accel_t;

    typedef struct packed {
        logic fast_down;
        logic slow_down;
        logic fast_front;
        logic slow_front;
        logic recording;
    } tilt_flags_t;

    typedef struct {
        logic              is_cfg;
        reg_idx_t          idx;
        logic [CFG_DW-1:0] val;
        accel_t            smp;
        logic              typed;
        tilt_flags_t       want;
    } dir_row_t;

    typedef enum int {
        POSE_FRONT,
        POSE_DOWN,
        POSE_TILT,
        POSE_NOISE
    } pose_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [CFG_DW-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_TW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_TW-1:0]   m_tdata;

    logic [ALPHA_W-1:0]  alpha_slow_r;
    logic [ALPHA_W-1:0]  alpha_fast_r;
    logic [C2_W-1:0]     cos_front_r;
    logic [C2_W-1:0]     cos_down_r;
    longint              slow_y [3];
    longint              fast_y [3];
    logic                rec_flag;

    tilt_flags_t         pending_tilt [$];
    dir_row_t            dir_table [DIR_ROWS];
    int                  mismatches = 0;
    int                  beats_seen = 0;
    int                  cycles = 0;
    int                  send_gap_max = 7;
    int                  recv_gap_max = 7;
    bit                  hold_req = 1'b0;

    dual_filter_tilt_detector_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("dual_filter_tilt_detector_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_seen, what, got, want);
        mismatches++;
    endtask

    function automatic longint filt_next(input longint y, input longint smp,
                                         input logic [ALPHA_W-1:0] a);
        longint d;
        longint p;
        d = smp * (longint'(1) << FRAC_BITS) - y;
        p = longint'(a) * d;
        return y + ((p + (longint'(1) << (ALPHA_W - 1))) >>> ALPHA_W);
    endfunction

    function automatic logic cone_pass(input longint comp, input longint n2,
                                       input logic [C2_W-1:0] c2, input logic neg_dir);
        longint unsigned lhs;
        longint unsigned rhs;
        if (neg_dir ? (comp >= 0) : (comp <= 0))
            return 1'b0;
        if (c2 >= C2_W'(65536))
            return 1'b0;
        lhs = longint'(comp * comp) << 16;
        rhs = longint'(c2) * n2;
        return lhs > rhs;
    endfunction

    task automatic advance_tilt(input accel_t smp, output tilt_flags_t f);
        longint raw [3];
        longint sv [3];
        longint fv [3];
        longint sn2;
        longint fn2;
        raw[0] = longint'(smp.x);
        raw[1] = longint'(smp.y);
        raw[2] = longint'(smp.z);
        sn2 = 0;
        fn2 = 0;
        for (int i = 0; i < 3; i++) begin
            slow_y[i] = filt_next(slow_y[i], raw[i], alpha_slow_r);
            fast_y[i] = filt_next(fast_y[i], raw[i], alpha_fast_r);
            sv[i] = slow_y[i] >>> (FRAC_BITS - TEST_FRAC);
            fv[i] = fast_y[i] >>> (FRAC_BITS - TEST_FRAC);
            sn2 += sv[i] * sv[i];
            fn2 += fv[i] * fv[i];
        end
        f.slow_front = cone_pass(sv[0], sn2, cos_front_r, 1'b1);
        f.fast_front = cone_pass(fv[0], fn2, cos_front_r, 1'b1);
        f.slow_down  = cone_pass(sv[2], sn2, cos_down_r, 1'b0);
        f.fast_down  = cone_pass(fv[2], fn2, cos_down_r, 1'b0);
        if (f.slow_front || f.fast_front)
            rec_flag = 1'b1;
        else if (f.slow_down && f.fast_down)
            rec_flag = 1'b0;
        f.recording = rec_flag;
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ALPHA_SLOW: alpha_slow_r = val[ALPHA_W-1:0];
            REG_ALPHA_FAST: alpha_fast_r = val[ALPHA_W-1:0];
            REG_COS_FRONT:  cos_front_r  = val[C2_W-1:0];
            REG_COS_DOWN:   cos_down_r   = val[C2_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // drop valid and hold until every pending beat is back
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_tilt.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_sample(input accel_t smp, input logic typed, input tilt_flags_t want);
        int gap;
        tilt_flags_t pred;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        advance_tilt(smp, pred);
        pending_tilt.push_back(typed ? want : pred);
    endtask

    function automatic accel_t pose_sample(input pose_t kind);
        accel_t s;
        int n [3];
        for (int i = 0; i < 3; i++)
            n[i] = int'($urandom_range(0, 4000)) - 2000;
        case (kind)
            POSE_FRONT: begin
                s.x = IN_W'(n[0] - 16384);
                s.y = IN_W'(n[1]);
                s.z = IN_W'(n[2]);
            end
            POSE_DOWN: begin
                s.x = IN_W'(n[0]);
                s.y = IN_W'(n[1]);
                s.z = IN_W'(n[2] + 16384);
            end
            POSE_TILT: begin
                s.x = IN_W'(int'($urandom_range(0, 40000)) - 20000);
                s.y = IN_W'(int'($urandom_range(0, 40000)) - 20000);
                s.z = IN_W'(int'($urandom_range(0, 40000)) - 20000);
            end
            default: begin
                s.x = IN_W'($urandom);
                s.y = IN_W'($urandom);
                s.z = IN_W'($urandom);
            end
        endcase
        return s;
    endfunction

    function automatic dir_row_t row_cfg(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
        dir_row_t r;
        r = '{is_cfg: 1'b1, idx: idx, val: val, smp: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic dir_row_t row_smp(input int x, input int y, input int z);
        dir_row_t r;
        r = '{is_cfg: 1'b0, idx: REG_ALPHA_SLOW, val: '0, smp: '0, typed: 1'b0, want: '0};
        r.smp.x = IN_W'(x);
        r.smp.y = IN_W'(y);
        r.smp.z = IN_W'(z);
        return r;
    endfunction

    function automatic dir_row_t row_chk(input int x, input int y, input int z,
                                         input logic rec, input logic sf, input logic ff,
                                         input logic sd, input logic fd);
        dir_row_t r;
        r = row_smp(x, y, z);
        r.typed = 1'b1;
        r.want  = '{fast_down: fd, slow_down: sd, fast_front: ff, slow_front: sf,
                    recording: rec};
        return r;
    endfunction

    initial begin : result_sink
        int stall;
        tilt_flags_t got;
        tilt_flags_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = $urandom_range(0, recv_gap_max);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = tilt_flags_t'(m_tdata[4:0]);
            if (m_tdata[OUT_TW-1:5] != '0)
                report_mismatch("pad bits", int'(m_tdata[OUT_TW-1:5]), 0);
            if (pending_tilt.size() == 0) begin
                report_mismatch("beat with nothing pending", int'(got), 0);
            end else begin
                want = pending_tilt.pop_front();
                if (got.recording !== want.recording)
                    report_mismatch("recording", int'(got.recording),
                                    int'(want.recording));
                if (got.slow_front !== want.slow_front)
                    report_mismatch("slow_front", int'(got.slow_front),
                                    int'(want.slow_front));
                if (got.fast_front !== want.fast_front)
                    report_mismatch("fast_front", int'(got.fast_front),
                                    int'(want.fast_front));
                if (got.slow_down !== want.slow_down)
                    report_mismatch("slow_down", int'(got.slow_down),
                                    int'(want.slow_down));
                if (got.fast_down !== want.fast_down)
                    report_mismatch("fast_down", int'(got.fast_down),
                                    int'(want.fast_down));
            end
            beats_seen++;
        end
    end

    initial begin : stimulus
        logic [CFG_DW-1:0] as_v, af_v, cf_v, cd_v;
        pose_t kind;
        int run;
        int sent;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_ALPHA_SLOW;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;

        alpha_slow_r = ALPHA_SLOW_RST;
        alpha_fast_r = ALPHA_FAST_RST;
        cos_front_r  = COS_SQ_RST;
        cos_down_r   = COS_SQ_RST;
        for (int i = 0; i < 3; i++) begin
            slow_y[i] = 0;
            fast_y[i] = 0;
        end
        slow_y[2] = longint'(1) << (SAMPLE_BITS - 2 + FRAC_BITS);
        fast_y[2] = slow_y[2];
        rec_flag  = 1'b0;

        dir_table = '{
            row_chk(0, 0, 16384, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1),
            row_cfg(REG_ALPHA_SLOW, 17'h00000),
            row_cfg(REG_ALPHA_FAST, 17'h1FFFF),
            row_smp(-32768, 0, 0),
            row_smp(32767, 32767, 32767),
            row_smp(-32768, -32768, -32768),
            row_smp(-1, -1, -1),
            row_cfg(REG_COS_FRONT, 17'h00000),
            row_smp(-16384, 100, 100),
            row_cfg(REG_COS_FRONT, 17'h10000),
            row_cfg(REG_COS_DOWN, 17'h1FFFF),
            row_chk(5, -7, 3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
            row_cfg(REG_COS_DOWN, 17'h00000),
            row_chk(0, 0, 32767, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1),
            row_cfg(REG_ALPHA_SLOW, 17'h0FFFF),
            row_cfg(REG_COS_FRONT, 17'h00000),
            row_smp(0, 0, 0),
            row_smp(0, 0, 0),
            row_smp(0, 0, 0),
            row_cfg(REG_ALPHA_FAST, 17'h10000),
            row_smp(-32768, 32767, -32768),
            row_smp(32767, -32768, 32767)
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            if (dir_table[i].is_cfg) begin
                settle_idle();
                cfg_write(dir_table[i].idx, dir_table[i].val);
            end else begin
                send_sample(dir_table[i].smp, dir_table[i].typed, dir_table[i].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle_idle();
            case (phase)
                0: begin
                    as_v = CFG_DW'(328);
                    af_v = CFG_DW'(6554);
                    cf_v = CFG_DW'(49152);
                    cd_v = CFG_DW'(49152);
                end
                1: begin
                    as_v = CFG_DW'(65535);
                    af_v = CFG_DW'(65535);
                    cf_v = CFG_DW'(0);
                    cd_v = CFG_DW'(65536);
                end
                3: begin
                    as_v = CFG_DW'(0);
                    af_v = CFG_DW'(1);
                    cf_v = CFG_DW'(65535);
                    cd_v = CFG_DW'(1);
                end
                4: begin
                    as_v = CFG_DW'($urandom);
                    af_v = CFG_DW'($urandom);
                    cf_v = CFG_DW'($urandom);
                    cd_v = CFG_DW'($urandom);
                end
                default: begin
                    as_v = CFG_DW'($urandom_range(300, 30000));
                    af_v = CFG_DW'($urandom_range(3000, 65535));
                    cf_v = CFG_DW'($urandom_range(0, 65536));
                    cd_v = CFG_DW'($urandom_range(0, 65536));
                end
            endcase
            cfg_write(REG_ALPHA_SLOW, as_v);
            cfg_write(REG_ALPHA_FAST, af_v);
            cfg_write(REG_COS_FRONT, cf_v);
            cfg_write(REG_COS_DOWN, cd_v);

            send_gap_max = (phase == 6) ? 0 : 7;
            recv_gap_max = (phase == 6 || phase == 2) ? 0 : 7;
            if (phase == 5)
                hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run = $urandom_range(0, 99);
                if (run < 35) begin
                    kind = POSE_FRONT;
                    run  = $urandom_range(10, 120);
                end else if (run < 70) begin
                    kind = POSE_DOWN;
                    run  = $urandom_range(10, 120);
                end else if (run < 85) begin
                    kind = POSE_TILT;
                    run  = $urandom_range(1, 8);
                end else begin
                    kind = POSE_NOISE;
                    run  = $urandom_range(1, 8);
                end
                for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
                    send_sample(pose_sample(kind), 1'b0, '0);
                    sent++;
                    if (phase == 5 && sent == 120)
                        settle_idle();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_tilt.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("dual_filter_tilt_detector_core test passed");
        else
            $display("dual_filter_tilt_detector_core test failed");
        $finish;
    end

endmodule
